### src/smrs_pkg.sv
`default_nettype none
package smrs_pkg;

	// function codes of a request
	localparam logic [1:0] FUNC_SET  = 2'd0;
	localparam logic [1:0] FUNC_GET  = 2'd1;
	localparam logic [1:0] FUNC_LOAD = 2'd2;
	localparam logic [1:0] FUNC_MUL  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	// configuration register indexes
	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	// field widths
	localparam int CFG_W = 5;
	localparam int VAL_W = 32;
	localparam int RIX_W = 4;
	localparam int CIX_W = 4;

	// widths of counters between controller and datapath, sized for the largest build
	localparam int IDX_W = 9;
	localparam int ROW_W = 7;

	// controller to datapath
	typedef struct packed {
		logic             ready;
		logic             accept;
		logic             mul;
		logic [ROW_W-1:0] mrow;
		logic             rd;
		logic [IDX_W-1:0] rd_idx;
		logic             wr;
		logic             wr_shift;
		logic [IDX_W-1:0] wr_idx;
		logic             cnt_inc;
		logic             cnt_dec;
		logic             res_hit;
		logic             res_full;
		logic             mac;
		logic             acc_add;
		logic             acc_clr;
		logic             emit;
		logic             emit_mul;
		logic             last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic             in_valid;
		logic [1:0]       in_func;
		logic [1:0]       func;
		logic             in_range;
		logic             val_zero;
		logic             hit;
		logic             out_free;
		logic [IDX_W-1:0] n;
		logic [ROW_W-1:0] nr;
	} sts_t;

endpackage
`default_nettype wire

### src/smrs_if.sv
`default_nettype none
interface smrs_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [3:0]         row_index;
	logic [3:0]         col_index;
	logic signed [31:0] value_in;

	modport source (output valid, func, row_index, col_index, value_in, input ready);
	modport sink (input valid, func, row_index, col_index, value_in, output ready);
endinterface

interface smrs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value_out;
	logic [3:0]         out_row;
	logic               last;
	logic [1:0]         status;

	modport source (output valid, value_out, out_row, last, status, input ready);
	modport sink (input valid, value_out, out_row, last, status, output ready);
endinterface
`default_nettype wire

### src/smrs_ctrl.sv
`default_nettype none
module smrs_ctrl #(
	parameter int ENTRIES_PER_ROW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire smrs_pkg::sts_t sts,
	output smrs_pkg::cmd_t     cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_RESP   = 3'd3;
	localparam logic [2:0] S_MUL    = 3'd4;
	localparam logic [2:0] S_MEMIT  = 3'd5;

	localparam logic [smrs_pkg::IDX_W-1:0] EPR_C = smrs_pkg::IDX_W'(ENTRIES_PER_ROW);

	logic [2:0]                  state_q, state_d;
	logic [smrs_pkg::IDX_W-1:0]  c_q, c_d;
	logic [smrs_pkg::IDX_W-1:0]  idx_s1;
	logic                        pend_s1;
	logic                        v_s2;
	logic [smrs_pkg::ROW_W-1:0]  r_q, r_d;
	logic                        is_last;

	assign is_last = (r_q + smrs_pkg::ROW_W'(1)) == sts.nr;

	// next state and commands
	always_comb begin
		state_d = state_q;
		c_d     = c_q;
		r_d     = r_q;
		cmd     = '0;
		cmd.mrow = r_q;
		cmd.mul  = (state_q == S_MUL) || (state_q == S_MEMIT);
		case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (sts.in_valid) begin
					cmd.accept = 1'b1;
					c_d = '0;
					r_d = '0;
					case (sts.in_func)
						smrs_pkg::FUNC_LOAD: state_d = S_IDLE;
						smrs_pkg::FUNC_MUL: begin
							cmd.acc_clr = 1'b1;
							state_d = S_MUL;
						end
						default: state_d = S_SEARCH;
					endcase
				end
			end
			S_SEARCH: begin
				if (!sts.in_range) begin
					state_d = S_RESP;
				end else if (pend_s1 && sts.hit) begin
					if (sts.func == smrs_pkg::FUNC_GET) begin
						cmd.res_hit = 1'b1;
						state_d = S_RESP;
					end else if (sts.val_zero) begin
						c_d = idx_s1 + smrs_pkg::IDX_W'(1);
						state_d = S_SHIFT;
					end else begin
						cmd.wr = 1'b1;
						cmd.wr_idx = idx_s1;
						state_d = S_RESP;
					end
				end else if (!pend_s1 && c_q >= sts.n) begin
					// column not present
					if (sts.func == smrs_pkg::FUNC_SET && !sts.val_zero) begin
						if (sts.n >= EPR_C) begin
							cmd.res_full = 1'b1;
						end else begin
							cmd.wr = 1'b1;
							cmd.wr_idx = sts.n;
							cmd.cnt_inc = 1'b1;
						end
					end
					state_d = S_RESP;
				end else if (c_q < sts.n) begin
					cmd.rd = 1'b1;
					cmd.rd_idx = c_q;
					c_d = c_q + smrs_pkg::IDX_W'(1);
				end
			end
			S_SHIFT: begin
				// move each later pair one place down
				if (pend_s1) begin
					cmd.wr = 1'b1;
					cmd.wr_shift = 1'b1;
					cmd.wr_idx = idx_s1 - smrs_pkg::IDX_W'(1);
				end
				if (c_q < sts.n) begin
					cmd.rd = 1'b1;
					cmd.rd_idx = c_q;
					c_d = c_q + smrs_pkg::IDX_W'(1);
				end else if (!pend_s1) begin
					cmd.cnt_dec = 1'b1;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_MUL: begin
				cmd.mac = pend_s1;
				cmd.acc_add = v_s2;
				if (c_q < sts.n) begin
					cmd.rd = 1'b1;
					cmd.rd_idx = c_q;
					c_d = c_q + smrs_pkg::IDX_W'(1);
				end else if (!pend_s1 && !v_s2) begin
					state_d = S_MEMIT;
				end
			end
			S_MEMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_mul = 1'b1;
					cmd.last = is_last;
					cmd.acc_clr = 1'b1;
					c_d = '0;
					if (is_last) begin
						state_d = S_IDLE;
					end else begin
						r_d = r_q + smrs_pkg::ROW_W'(1);
						state_d = S_MUL;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			c_q     <= '0;
			r_q     <= '0;
			pend_s1 <= 1'b0;
			v_s2    <= 1'b0;
			idx_s1  <= '0;
		end else begin
			state_q <= state_d;
			c_q     <= c_d;
			r_q     <= r_d;
			pend_s1 <= cmd.rd;
			v_s2    <= cmd.mac;
			idx_s1  <= c_q;
		end
	end

endmodule
`default_nettype wire

### src/smrs_dp.sv
`default_nettype none
module smrs_dp #(
	parameter int MAX_ROWS        = 16,
	parameter int MAX_COLS        = 16,
	parameter int ENTRIES_PER_ROW = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	smrs_in_if.sink                          req,
	smrs_out_if.source                       rsp,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [smrs_pkg::CFG_W-1:0]  cfg_data,
	input  wire smrs_pkg::cmd_t              cmd,
	output smrs_pkg::sts_t                   sts
);

	localparam int DEPTH  = MAX_ROWS * ENTRIES_PER_ROW;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int VAW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CW     = $clog2(ENTRIES_PER_ROW + 1);
	localparam int NRW    = $clog2(MAX_ROWS + 1);
	localparam int NCW    = $clog2(MAX_COLS + 1);
	localparam int ACC_W  = 49 + $clog2(ENTRIES_PER_ROW + 1);
	localparam int EW     = smrs_pkg::CIX_W + smrs_pkg::VAL_W;
	localparam int RST_NR = (MAX_ROWS < 16) ? MAX_ROWS : 16;
	localparam int RST_NC = (MAX_COLS < 16) ? MAX_COLS : 16;

	// entry store: column in the upper bits, value below
	logic [EW-1:0] ent_mem [DEPTH];
	logic [EW-1:0] rdata_q;

	logic [CW-1:0]  cnt_q [MAX_ROWS];
	logic signed [smrs_pkg::VAL_W-1:0] vec_mem [MAX_COLS];

	logic [NRW-1:0] nr_q;
	logic [NCW-1:0] nc_q;

	logic [1:0]                          func_q;
	logic [smrs_pkg::RIX_W-1:0]          row_q;
	logic [smrs_pkg::CIX_W-1:0]          col_q;
	logic signed [smrs_pkg::VAL_W-1:0]   val_q;
	logic signed [smrs_pkg::VAL_W-1:0]   res_q;
	logic [1:0]                          res_stat_q;

	logic signed [63:0]      prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	logic                              ovalid_q;
	logic signed [smrs_pkg::VAL_W-1:0] oval_q;
	logic [smrs_pkg::RIX_W-1:0]        orow_q;
	logic                              olast_q;
	logic [1:0]                        ostat_q;

	logic [31:0]           sel_row;
	logic [RAW-1:0]        cnt_ix;
	logic [RAW-1:0]        item_ix;
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic [EW-1:0]         wdata;
	logic [smrs_pkg::CIX_W-1:0]        rd_col;
	logic signed [smrs_pkg::VAL_W-1:0] rd_val;
	logic signed [smrs_pkg::VAL_W-1:0] vec_x;
	logic [31:0]           rd_col32;
	logic [31:0]           in_col32;
	logic [31:0]           item_row32;
	logic signed [63:0]    term;
	logic                  sat_hi;
	logic                  sat_lo;
	logic [31:0]           cfg_clamp_r;
	logic [31:0]           cfg_clamp_c;
	logic                  out_free;

	function automatic logic [31:0] clamp_cnt(input logic [smrs_pkg::CFG_W-1:0] v,
			input int maxv);
		logic [31:0] x;
		x = 32'(v);
		if (x == 32'd0) begin
			x = 32'd1;
		end
		if (x > 32'(maxv)) begin
			x = 32'(maxv);
		end
		return x;
	endfunction

	assign cfg_clamp_r = clamp_cnt(cfg_data, MAX_ROWS);
	assign cfg_clamp_c = clamp_cnt(cfg_data, MAX_COLS);

	// address and index selection
	assign item_row32 = 32'(row_q);
	assign item_ix    = item_row32[RAW-1:0];
	assign sel_row    = cmd.mul ? 32'(cmd.mrow) : item_row32;
	assign cnt_ix     = sel_row[RAW-1:0];

	always_comb begin
		logic [31:0] ra;
		logic [31:0] wa;
		ra = sel_row * 32'(ENTRIES_PER_ROW) + 32'(cmd.rd_idx);
		wa = item_row32 * 32'(ENTRIES_PER_ROW) + 32'(cmd.wr_idx);
		raddr = ra[AW-1:0];
		waddr = wa[AW-1:0];
	end

	assign rd_col = rdata_q[EW-1:smrs_pkg::VAL_W];
	assign rd_val = rdata_q[smrs_pkg::VAL_W-1:0];
	assign wdata  = cmd.wr_shift ? rdata_q : {col_q, val_q};

	// entry store ports
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			ent_mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= ent_mem[raddr];
		end
	end

	// operand vector store
	assign in_col32 = 32'(req.col_index);
	always_ff @(posedge clk) begin
		if (cmd.accept && req.func == smrs_pkg::FUNC_LOAD && in_col32 < 32'(nc_q)) begin
			vec_mem[in_col32[VAW-1:0]] <= req.value_in;
		end
	end

	assign rd_col32 = 32'(rd_col);
	assign vec_x = (rd_col32 < 32'(MAX_COLS)) ? vec_mem[rd_col32[VAW-1:0]] : '0;

	// row counts and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ROWS; i++) begin
				cnt_q[i] <= '0;
			end
			nr_q <= NRW'(RST_NR);
			nc_q <= NCW'(RST_NC);
		end else begin
			if (cfg_we && cfg_index == smrs_pkg::REG_NUM_ROWS) begin
				nr_q <= cfg_clamp_r[NRW-1:0];
				for (int i = 0; i < MAX_ROWS; i++) begin
					if (32'(i) >= cfg_clamp_r) begin
						cnt_q[i] <= '0;
					end
				end
			end else if (cmd.cnt_inc) begin
				cnt_q[item_ix] <= cnt_q[item_ix] + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q[item_ix] <= cnt_q[item_ix] - CW'(1);
			end
			if (cfg_we && cfg_index == smrs_pkg::REG_NUM_COLS) begin
				nc_q <= cfg_clamp_c[NCW-1:0];
			end
		end
	end

	// request latch and set/get result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q     <= req.func;
			row_q      <= req.row_index;
			col_q      <= req.col_index;
			val_q      <= req.value_in;
			res_q      <= '0;
			res_stat_q <= smrs_pkg::ST_OK;
		end else begin
			if (cmd.res_hit) begin
				res_q <= rd_val;
			end
			if (cmd.res_full) begin
				res_stat_q <= smrs_pkg::ST_FULL;
			end
		end
	end

	// multiply and accumulate
	assign term = (prod_s2 + 64'sd32768) >>> 16;
	always_ff @(posedge clk) begin
		if (cmd.mac) begin
			prod_s2 <= 64'(rd_val) * 64'(vec_x);
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + ACC_W'(term);
		end
	end

	assign sat_hi = acc_q > ACC_W'(64'sh7FFF_FFFF);
	assign sat_lo = acc_q < -ACC_W'(64'sh8000_0000);

	// output register
	assign out_free = !ovalid_q || rsp.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (cmd.emit_mul) begin
				orow_q  <= cmd.mrow[smrs_pkg::RIX_W-1:0];
				olast_q <= cmd.last;
				if (sat_hi) begin
					oval_q  <= 32'sh7FFF_FFFF;
					ostat_q <= smrs_pkg::ST_SAT;
				end else if (sat_lo) begin
					oval_q  <= 32'sh8000_0000;
					ostat_q <= smrs_pkg::ST_SAT;
				end else begin
					oval_q  <= acc_q[smrs_pkg::VAL_W-1:0];
					ostat_q <= smrs_pkg::ST_OK;
				end
			end else begin
				orow_q  <= row_q;
				olast_q <= 1'b1;
				oval_q  <= res_q;
				ostat_q <= res_stat_q;
			end
		end
	end

	assign rsp.valid     = ovalid_q;
	assign rsp.value_out = oval_q;
	assign rsp.out_row   = orow_q;
	assign rsp.last      = olast_q;
	assign rsp.status    = ostat_q;
	assign req.ready     = cmd.ready;

	// status to controller
	always_comb begin
		sts          = '0;
		sts.in_valid = req.valid;
		sts.in_func  = req.func;
		sts.func     = func_q;
		sts.in_range = (32'(row_q) < 32'(nr_q)) && (32'(col_q) < 32'(nc_q));
		sts.val_zero = (val_q == '0);
		sts.hit      = (rd_col == col_q);
		sts.out_free = out_free;
		sts.n        = smrs_pkg::IDX_W'(cnt_q[cnt_ix]);
		sts.nr       = smrs_pkg::ROW_W'(nr_q);
	end

endmodule
`default_nettype wire

### src/sparse_matrix_row_store_spmv_unit.sv
`default_nettype none
// Sparse matrix row store with matrix-vector multiply.
// Requests arrive on req (func, row_index, col_index, value_in); results leave on rsp
// (value_out, out_row, last, status), both valid/ready. The row count and column
// count registers are written through cfg_we/cfg_index/cfg_data; the user must
// do so only while the unit is idle, the block does not enforce it. A request is
// taken only when the unit is idle; one request is worked at a time. Set and get
// scan the row's pair list in one entry memory with separate read and write ports,
// one pair per cycle; a removal shifts the later pairs down. Load gives no result.
// Multiply walks every stored pair through a read, a 32x32 multiply and an
// accumulate stage, one result per row, last set on the final row.
// Results sit in an output register; while rsp stalls the next result waits in
// the sequencer, which takes no new request until that result is placed.
// Reset empties all rows and sets both registers to 16 (MAX_ROWS or MAX_COLS if
// smaller); entry memory and vector store are not cleared, there is no clearing pass.
module sparse_matrix_row_store_spmv_unit #(
	parameter int MAX_ROWS        = 16,
	parameter int MAX_COLS        = 16,
	parameter int ENTRIES_PER_ROW = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	smrs_in_if.sink                         req,
	smrs_out_if.source                      rsp,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [smrs_pkg::CFG_W-1:0] cfg_data
);

	smrs_pkg::cmd_t cmd;
	smrs_pkg::sts_t sts;

	// sequencer
	smrs_ctrl #(
		.ENTRIES_PER_ROW(ENTRIES_PER_ROW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sts(sts),
		.cmd(cmd)
	);

	// storage and arithmetic
	smrs_dp #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.ENTRIES_PER_ROW(ENTRIES_PER_ROW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.sts(sts)
	);

endmodule
`default_nettype wire
